// ===== sv/sgrpd_pkg.sv =====
// ----------------------------------------------------------------------------
// sgrpd_pkg
// shared types, constants and palette lookup for the sgr pen decoder
// ----------------------------------------------------------------------------
package sgrpd_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [24:0] COLOR_DEFAULT = 25'h1000000;

    localparam logic [5:0] F_EXPLICIT  = 6'h01;
    localparam logic [5:0] F_BOLD      = 6'h02;
    localparam logic [5:0] F_DIM       = 6'h04;
    localparam logic [5:0] F_ITALIC    = 6'h08;
    localparam logic [5:0] F_UNDERLINE = 6'h10;
    localparam logic [5:0] F_REVERSE   = 6'h20;

    // sgr codes that the front end looks for
    localparam logic [7:0] SGR_RESET      = 8'd0;
    localparam logic [7:0] SGR_BOLD       = 8'd1;
    localparam logic [7:0] SGR_DIM        = 8'd2;
    localparam logic [7:0] SGR_ITALIC     = 8'd3;
    localparam logic [7:0] SGR_UNDERLINE  = 8'd4;
    localparam logic [7:0] SGR_REVERSE    = 8'd7;
    localparam logic [7:0] SGR_NORMAL     = 8'd22;
    localparam logic [7:0] SGR_NO_ITALIC  = 8'd23;
    localparam logic [7:0] SGR_NO_ULINE   = 8'd24;
    localparam logic [7:0] SGR_NO_REVERSE = 8'd27;
    localparam logic [7:0] SGR_FG_BASE    = 8'd30;
    localparam logic [7:0] SGR_FG_EXT     = 8'd38;
    localparam logic [7:0] SGR_FG_DEFAULT = 8'd39;
    localparam logic [7:0] SGR_BG_BASE    = 8'd40;
    localparam logic [7:0] SGR_BG_EXT     = 8'd48;
    localparam logic [7:0] SGR_BG_DEFAULT = 8'd49;
    localparam logic [7:0] SGR_FG_BRIGHT  = 8'd90;
    localparam logic [7:0] SGR_BG_BRIGHT  = 8'd100;
    localparam logic [7:0] SEL_INDEXED    = 8'd5;
    localparam logic [7:0] SEL_RGB        = 8'd2;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_SEL   = 6'b000010,
        PH_INDEX = 6'b000100,
        PH_RED   = 6'b001000,
        PH_GREEN = 6'b010000,
        PH_BLUE  = 6'b100000
    } phase_t;

    // one decoded pen update
    typedef struct packed {
        logic        pen_reset;
        logic [5:0]  set_mask;
        logic [5:0]  clr_mask;
        logic        fg_we;
        logic        bg_we;
        logic [24:0] color;
        logic        count_inc;
    } pen_cmd_t;

    function automatic logic [23:0] base16(input logic [3:0] idx);
        logic [23:0] c;
        case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'hcd3131;
            4'd2:    c = 24'h0dbc79;
            4'd3:    c = 24'he5e510;
            4'd4:    c = 24'h2472c8;
            4'd5:    c = 24'hbc3fbc;
            4'd6:    c = 24'h11a8cd;
            4'd7:    c = 24'he5e5e5;
            4'd8:    c = 24'h666666;
            4'd9:    c = 24'hf14c4c;
            4'd10:   c = 24'h23d18b;
            4'd11:   c = 24'hf5f543;
            4'd12:   c = 24'h3b8eea;
            4'd13:   c = 24'hd670d6;
            4'd14:   c = 24'h29b8db;
            default: c = 24'hffffff;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cube_level(input logic [2:0] idx);
        logic [7:0] l;
        case (idx)
            3'd0:    l = 8'd0;
            3'd1:    l = 8'd95;
            3'd2:    l = 8'd135;
            3'd3:    l = 8'd175;
            3'd4:    l = 8'd215;
            default: l = 8'd255;
        endcase
        return l;
    endfunction

    // 256-entry palette: fixed colors, 6x6x6 cube, gray ramp
    function automatic logic [23:0] palette(input logic [7:0] n);
        logic [7:0]  v;
        logic [13:0] prod1;
        logic [2:0]  q36;
        logic [7:0]  r36_full;
        logic [5:0]  r36;
        logic [13:0] prod2;
        logic [2:0]  q6;
        logic [5:0]  r6_full;
        logic [2:0]  r6;
        logic [7:0]  g;
        logic [23:0] res;
        v        = n - 8'd16;
        // v / 36 as a reciprocal multiply, exact for v below 216
        prod1    = 14'(v) * 14'd57;
        q36      = prod1[13:11];
        r36_full = v - 8'({5'b0, q36}) * 8'd36;
        r36      = r36_full[5:0];
        // r / 6, exact for r below 36
        prod2    = 14'(r36) * 14'd43;
        q6       = prod2[10:8];
        r6_full  = r36 - 6'({3'b0, q6}) * 6'd6;
        r6       = r6_full[2:0];
        g        = 8'd8 + (n - 8'd232) * 8'd10;
        if (n < 8'd16) begin
            res = base16(n[3:0]);
        end
        else if (n < 8'd232) begin
            res = {cube_level(q36), cube_level(q6), cube_level(r6)};
        end
        else begin
            res = {g, g, g};
        end
        return res;
    endfunction

endpackage

// ===== sv/sgrpd_front.sv =====
// ----------------------------------------------------------------------------
// sgrpd_front
// classifies each parameter into a pen update and tracks extended colors
// ----------------------------------------------------------------------------
module sgrpd_front
    import sgrpd_pkg::*;
#(
    parameter int unsigned PARAM_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [PARAM_WIDTH-1:0] param_value,
    input  logic                   is_last,
    input  logic                   accept,
    output pen_cmd_t               cmd
);

    phase_t     phase_reg, phase_next;
    logic       target_bg_reg, target_bg_next;
    logic [7:0] red_hold_reg, red_hold_next;
    logic [7:0] green_hold_reg, green_hold_next;
    logic       skip_rest_reg, skip_rest_next;

    logic       byte_ok;
    logic [7:0] lo;

    assign byte_ok = ~|param_value[PARAM_WIDTH-1:8];
    assign lo      = param_value[7:0];

    always_comb
    begin
        cmd             = '0;
        phase_next      = phase_reg;
        target_bg_next  = target_bg_reg;
        red_hold_next   = red_hold_reg;
        green_hold_next = green_hold_reg;
        skip_rest_next  = skip_rest_reg;

        if (!skip_rest_reg)
        begin
            case (phase_reg)
                PH_SEL:
                begin
                    if (byte_ok && lo == SEL_INDEXED)
                    begin
                        phase_next = PH_INDEX;
                    end
                    else if (byte_ok && lo == SEL_RGB)
                    begin
                        phase_next = PH_RED;
                    end
                    else
                    begin
                        cmd.count_inc  = 1'b1;
                        phase_next     = PH_IDLE;
                        skip_rest_next = 1'b1;
                    end
                end
                PH_INDEX, PH_BLUE:
                begin
                    if (byte_ok)
                    begin
                        cmd.color  = (phase_reg == PH_INDEX) ? {1'b0, palette(lo)}
                                                             : {1'b0, red_hold_reg,
                                                                green_hold_reg, lo};
                        cmd.fg_we  = ~target_bg_reg;
                        cmd.bg_we  = target_bg_reg;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        cmd.count_inc  = 1'b1;
                        phase_next     = PH_IDLE;
                        skip_rest_next = 1'b1;
                    end
                end
                PH_RED, PH_GREEN:
                begin
                    if (byte_ok)
                    begin
                        if (phase_reg == PH_RED)
                        begin
                            red_hold_next = lo;
                            phase_next    = PH_GREEN;
                        end
                        else
                        begin
                            green_hold_next = lo;
                            phase_next      = PH_BLUE;
                        end
                    end
                    else
                    begin
                        cmd.count_inc  = 1'b1;
                        phase_next     = PH_IDLE;
                        skip_rest_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (!byte_ok)
                    begin
                        cmd.count_inc = 1'b1;
                    end
                    else if (lo == SGR_RESET)
                    begin
                        cmd.pen_reset = 1'b1;
                    end
                    else if (lo == SGR_BOLD)
                    begin
                        cmd.set_mask = F_BOLD;
                    end
                    else if (lo == SGR_DIM)
                    begin
                        cmd.set_mask = F_DIM;
                    end
                    else if (lo == SGR_ITALIC)
                    begin
                        cmd.set_mask = F_ITALIC;
                    end
                    else if (lo == SGR_UNDERLINE)
                    begin
                        cmd.set_mask = F_UNDERLINE;
                    end
                    else if (lo == SGR_REVERSE)
                    begin
                        cmd.set_mask = F_REVERSE;
                    end
                    else if (lo == SGR_NORMAL)
                    begin
                        cmd.clr_mask = F_BOLD | F_DIM;
                    end
                    else if (lo == SGR_NO_ITALIC)
                    begin
                        cmd.clr_mask = F_ITALIC;
                    end
                    else if (lo == SGR_NO_ULINE)
                    begin
                        cmd.clr_mask = F_UNDERLINE;
                    end
                    else if (lo == SGR_NO_REVERSE)
                    begin
                        cmd.clr_mask = F_REVERSE;
                    end
                    else if (lo == SGR_FG_DEFAULT)
                    begin
                        cmd.fg_we = 1'b1;
                        cmd.color = COLOR_DEFAULT;
                    end
                    else if (lo == SGR_BG_DEFAULT)
                    begin
                        cmd.bg_we = 1'b1;
                        cmd.color = COLOR_DEFAULT;
                    end
                    else if (lo >= SGR_FG_BASE && lo <= SGR_FG_BASE + 8'd7)
                    begin
                        cmd.fg_we = 1'b1;
                        cmd.color = {1'b0, palette(lo - SGR_FG_BASE)};
                    end
                    else if (lo >= SGR_BG_BASE && lo <= SGR_BG_BASE + 8'd7)
                    begin
                        cmd.bg_we = 1'b1;
                        cmd.color = {1'b0, palette(lo - SGR_BG_BASE)};
                    end
                    else if (lo >= SGR_FG_BRIGHT && lo <= SGR_FG_BRIGHT + 8'd7)
                    begin
                        cmd.fg_we = 1'b1;
                        cmd.color = {1'b0, palette(lo - SGR_FG_BRIGHT + 8'd8)};
                    end
                    else if (lo >= SGR_BG_BRIGHT && lo <= SGR_BG_BRIGHT + 8'd7)
                    begin
                        cmd.bg_we = 1'b1;
                        cmd.color = {1'b0, palette(lo - SGR_BG_BRIGHT + 8'd8)};
                    end
                    else if (lo == SGR_FG_EXT || lo == SGR_BG_EXT)
                    begin
                        target_bg_next = (lo == SGR_BG_EXT);
                        phase_next     = PH_SEL;
                    end
                    else
                    begin
                        cmd.count_inc = 1'b1;
                    end
                end
            endcase

            // sequence ends with an extended color still open
            if (is_last && phase_next != PH_IDLE)
            begin
                cmd.count_inc = 1'b1;
            end
        end

        if (is_last)
        begin
            phase_next     = PH_IDLE;
            skip_rest_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            target_bg_reg  <= 1'b0;
            red_hold_reg   <= 8'd0;
            green_hold_reg <= 8'd0;
            skip_rest_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            target_bg_reg  <= target_bg_next;
            red_hold_reg   <= red_hold_next;
            green_hold_reg <= green_hold_next;
            skip_rest_reg  <= skip_rest_next;
        end
    end

endmodule

// ===== sv/sgrpd_queue.sv =====
// ----------------------------------------------------------------------------
// sgrpd_queue
// small command queue between the classifier and the pen update
// ----------------------------------------------------------------------------
module sgrpd_queue
    import sgrpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pen_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output pen_cmd_t pop_cmd
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    pen_cmd_t entry_reg [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/sgrpd_back.sv =====
// ----------------------------------------------------------------------------
// sgrpd_back
// applies pen updates and holds the pen as the result register
// ----------------------------------------------------------------------------
module sgrpd_back
    import sgrpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  pen_cmd_t    cmd,
    output logic        cmd_pop,
    output logic        pen_valid,
    input  logic        pen_ready,
    output logic [5:0]  pen_flags,
    output logic [24:0] fg_color,
    output logic [24:0] bg_color,
    output logic [63:0] unsupported_count
);

    logic [5:0]  flags_reg, flags_next;
    logic [24:0] fg_reg, fg_next;
    logic [24:0] bg_reg, bg_next;
    logic [63:0] unsup_reg, unsup_next;
    logic        valid_reg;

    // result slot is free or drains this cycle
    assign cmd_pop = cmd_valid && (!valid_reg || pen_ready);

    always_comb
    begin
        flags_next = (flags_reg | cmd.set_mask) & ~cmd.clr_mask;
        fg_next    = cmd.fg_we ? cmd.color : fg_reg;
        bg_next    = cmd.bg_we ? cmd.color : bg_reg;
        unsup_next = unsup_reg;
        if (cmd.pen_reset)
        begin
            flags_next = F_EXPLICIT;
            fg_next    = COLOR_DEFAULT;
            bg_next    = COLOR_DEFAULT;
        end
        if (cmd.count_inc && unsup_reg != '1)
        begin
            unsup_next = unsup_reg + 64'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            fg_reg    <= COLOR_DEFAULT;
            bg_reg    <= COLOR_DEFAULT;
            unsup_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                flags_reg <= flags_next;
                fg_reg    <= fg_next;
                bg_reg    <= bg_next;
                unsup_reg <= unsup_next;
                valid_reg <= 1'b1;
            end
            else if (pen_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign pen_valid         = valid_reg;
    assign pen_flags         = flags_reg;
    assign fg_color          = fg_reg;
    assign bg_color          = bg_reg;
    assign unsupported_count = unsup_reg;

endmodule

// ===== sv/sgr_pen_attribute_decoder.sv =====
// path: an accepted parameter is classified and pushed into the command queue,
// then popped into the pen result register that drives the pen channel
// throughput: one parameter per cycle, sustained while the result side takes a pen
// each cycle; a two-entry command queue and the pen result register set this
// reset: rst_n low clears the queue, returns the extended-color tracker to idle,
// and sets the pen to no flags, default colors and a zero unsupported count
// ----------------------------------------------------------------------------
// sgr_pen_attribute_decoder
// decodes sgr parameters into a pen of flags, colors and an unsupported count
// ----------------------------------------------------------------------------
module sgr_pen_attribute_decoder
    import sgrpd_pkg::*;
#(
    parameter int unsigned PARAM_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // parameter channel
    input  logic                   param_valid,
    output logic                   param_ready,
    input  logic [PARAM_WIDTH-1:0] param_value,
    input  logic                   is_last,
    // pen channel, one transfer per parameter
    output logic                   pen_valid,
    input  logic                   pen_ready,
    output logic [5:0]             pen_flags,
    output logic [24:0]            fg_color,
    output logic [24:0]            bg_color,
    output logic [63:0]            unsupported_count
);

    logic     q_full;
    logic     q_not_empty;
    logic     q_pop;
    logic     accept;
    pen_cmd_t front_cmd;
    pen_cmd_t back_cmd;

    // front takes a parameter whenever the queue has room,
    // independent of whether the pen result has been taken
    assign param_ready = ~q_full;
    assign accept      = param_valid & param_ready;

    // front: sequence tracking, palette lookup and code classification
    sgrpd_front #(
        .PARAM_WIDTH (PARAM_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .param_value (param_value),
        .is_last     (is_last),
        .accept      (accept),
        .cmd         (front_cmd)
    );

    // decouples the classifier from result-side stalls
    sgrpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (back_cmd)
    );

    // back: pen state, which doubles as the result register
    sgrpd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (q_not_empty),
        .cmd               (back_cmd),
        .cmd_pop           (q_pop),
        .pen_valid         (pen_valid),
        .pen_ready         (pen_ready),
        .pen_flags         (pen_flags),
        .fg_color          (fg_color),
        .bg_color          (bg_color),
        .unsupported_count (unsupported_count)
    );

endmodule
